// ===== design/ddec_pkg.sv =====
// Package: shared types and constants for the debounced drive-enable controller.
package ddec_pkg;

    localparam int unsigned GEN_WIDTH_DEFAULT = 8;
    localparam int unsigned GEN_OUT_W         = 8;
    localparam int unsigned DEB_W             = 16;
    localparam int unsigned TIME_W            = 32;
    localparam int unsigned CFG_DATA_W        = 16;
    localparam int unsigned CFG_INDEX_W       = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW  = 1'd1;

    localparam logic [DEB_W-1:0] DEBOUNCE_MS_RESET = 16'd30;
    localparam logic             ACTIVE_LOW_RESET  = 1'b1;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
        logic              selected_blue;
        logic [7:0]        pose_generation;
        logic [7:0]        map_generation;
    } in_item_t;

    typedef struct packed {
        logic                 drive_on;
        logic                 start_waiting;
        logic                 home_blue;
        logic [GEN_OUT_W-1:0] request_generation;
        logic                 discard_commands;
        logic                 new_home_request;
    } out_item_t;

    // Events passed from the debouncer to the enable sequencer
    typedef struct packed {
        logic toggle;
    } btn_event_t;

endpackage

// ===== design/ddec_debounce.sv =====
// Button polarity correction, time-based debounce and release arming.
module ddec_debounce (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       pin_level,
    input  logic [ddec_pkg::TIME_W-1:0] now_ms,
    input  logic [ddec_pkg::DEB_W-1:0]  debounce_ms,
    input  logic                       active_low,
    output ddec_pkg::btn_event_t       events
);

    logic                        primed_reg, primed_next;
    logic                        raw_reg, raw_next;
    logic                        stable_reg, stable_next;
    logic                        armed_reg, armed_next;
    logic [ddec_pkg::TIME_W-1:0] changed_reg, changed_next;

    logic                        pressed;
    logic                        raw0, stable0, armed0, armed1;
    logic [ddec_pkg::TIME_W-1:0] changed0;
    logic [ddec_pkg::TIME_W-1:0] elapsed;
    logic                        settled, stable_edge, toggle;

    always_comb
    begin
        pressed  = active_low ? ~pin_level : pin_level;
        // first sample primes raw and stable to the current level
        raw0     = primed_reg ? raw_reg    : pressed;
        stable0  = primed_reg ? stable_reg : pressed;
        changed0 = primed_reg ? changed_reg : now_ms;
        armed0   = primed_reg & armed_reg;

        raw_next     = pressed;
        changed_next = (pressed != raw0) ? now_ms : changed0;
        elapsed      = now_ms - changed_next;
        settled      = elapsed >= ddec_pkg::TIME_W'(debounce_ms);

        armed1      = armed0 | (settled & ~pressed);
        stable_edge = settled & (pressed != stable0);
        stable_next = stable_edge ? pressed : stable0;
        toggle      = stable_edge & pressed & armed1;
        armed_next  = armed1 & ~toggle;
        primed_next = 1'b1;

        events.toggle = toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg  <= 1'b0;
            raw_reg     <= 1'b0;
            stable_reg  <= 1'b0;
            armed_reg   <= 1'b0;
            changed_reg <= '0;
        end
        else if (advance)
        begin
            primed_reg  <= primed_next;
            raw_reg     <= raw_next;
            stable_reg  <= stable_next;
            armed_reg   <= armed_next;
            changed_reg <= changed_next;
        end
    end

endmodule

// ===== design/ddec_enable.sv =====
// Drive-enable sequencer: start toggling, home latch, generation and readiness.
module ddec_enable #(
    parameter int unsigned GEN_WIDTH = ddec_pkg::GEN_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  ddec_pkg::btn_event_t  events,
    input  logic                  selected_blue,
    input  logic [7:0]            pose_generation,
    input  logic [7:0]            map_generation,
    output ddec_pkg::out_item_t   result
);

    localparam int unsigned CMP_W = (GEN_WIDTH > ddec_pkg::GEN_OUT_W) ?
                                    GEN_WIDTH : ddec_pkg::GEN_OUT_W;

    logic                 enabled_reg, enabled_next;
    logic                 pending_reg, pending_next;
    logic                 blue_reg, blue_next;
    logic [GEN_WIDTH-1:0] gen_reg, gen_next;

    logic             starting, fresh_base, bumped, ready, pending1;
    logic [CMP_W-1:0] gen_ext;

    always_comb
    begin
        enabled_next = enabled_reg;
        pending1     = pending_reg;
        blue_next    = blue_reg;
        gen_next     = gen_reg;
        bumped       = 1'b0;
        starting     = ~enabled_reg & ~pending_reg;
        fresh_base   = (gen_reg == '0) | (selected_blue != blue_reg);

        if (events.toggle)
        begin
            enabled_next = 1'b0;
            pending1     = starting;
            if (starting && fresh_base)
            begin
                blue_next = selected_blue;
                gen_next  = gen_reg + GEN_WIDTH'(1);
                bumped    = 1'b1;
            end
        end

        gen_ext = CMP_W'(gen_next);
        ready   = pending1 & (CMP_W'(pose_generation) == gen_ext)
                           & (CMP_W'(map_generation) == gen_ext);
        pending_next = pending1 & ~ready;
        if (ready)
        begin
            enabled_next = 1'b1;
        end

        result.drive_on           = enabled_next;
        result.start_waiting      = pending_next;
        result.home_blue          = blue_next;
        result.request_generation = gen_ext[ddec_pkg::GEN_OUT_W-1:0];
        result.discard_commands   = events.toggle | ready;
        result.new_home_request   = bumped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            pending_reg <= 1'b0;
            blue_reg    <= 1'b0;
            gen_reg     <= '0;
        end
        else if (advance)
        begin
            enabled_reg <= enabled_next;
            pending_reg <= pending_next;
            blue_reg    <= blue_next;
            gen_reg     <= gen_next;
        end
    end

endmodule

// ===== design/debounced_drive_enable_controller_top.sv =====
// Top level of the debounced drive-enable controller: item pipeline and config.
// Items pass the input register, then the result register. Throughput: one item per
// cycle while out_stall is low; the input register feeds the result register through
// one pass of debounce and sequencer logic (a 32-bit subtract and compare).
// Reset (rst_n, asynchronous, active low) clears all control state and loads
// debounce_ms = 30 and active_low = 1; no clearing pass is needed.
module debounced_drive_enable_controller_top #(
    parameter int unsigned GEN_WIDTH = ddec_pkg::GEN_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input item channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ddec_pkg::in_item_t               in_item,
    // result item channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output ddec_pkg::out_item_t              out_item,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [ddec_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ddec_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [ddec_pkg::DEB_W-1:0] debounce_reg;
    logic                       active_low_reg;

    // Input register stage
    logic                  in_valid_reg;
    ddec_pkg::in_item_t    in_item_reg;

    // Result register stage
    logic                  out_valid_reg;
    ddec_pkg::out_item_t   out_item_reg;

    logic                  out_free;
    logic                  advance;
    logic                  in_take;
    ddec_pkg::btn_event_t  events;
    ddec_pkg::out_item_t   result;

    // The result register takes a new item when empty or when its item leaves.
    // An item held in the input register moves on whenever that is so, and
    // only then does the state of the debouncer and sequencer advance.
    assign out_free = ~out_valid_reg | ~out_stall;
    assign advance  = in_valid_reg & out_free;
    // The input register is free when empty or when its item advances this cycle
    assign in_stall = in_valid_reg & ~out_free;
    assign in_take  = in_valid & ~in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= ddec_pkg::DEBOUNCE_MS_RESET;
            active_low_reg <= ddec_pkg::ACTIVE_LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddec_pkg::REG_DEBOUNCE_MS: debounce_reg   <= cfg_data;
                ddec_pkg::REG_ACTIVE_LOW:  active_low_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Hold the input item until it advances; refill in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
    end

    // Hold the result until taken; drop valid once it leaves with nothing behind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    ddec_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pin_level   (in_item_reg.pin_level),
        .now_ms      (in_item_reg.now_ms),
        .debounce_ms (debounce_reg),
        .active_low  (active_low_reg),
        .events      (events)
    );

    ddec_enable #(
        .GEN_WIDTH (GEN_WIDTH)
    ) u_enable (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .events          (events),
        .selected_blue   (in_item_reg.selected_blue),
        .pose_generation (in_item_reg.pose_generation),
        .map_generation  (in_item_reg.map_generation),
        .result          (result)
    );

endmodule
